FILE: hdl/sm83_alu_flags_unit_core_macros.svh
// ----------------------------------------------------------------------------
// sm83 alu flags unit assertion macros
// shared concurrent assertion forms for the execute unit
// ----------------------------------------------------------------------------
`ifndef SM83_ALU_FLAGS_UNIT_CORE_MACROS_SVH
`define SM83_ALU_FLAGS_UNIT_CORE_MACROS_SVH

// checked on every edge outside reset
`define SM83AF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SM83AF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/sm83af_pkg.sv
// ----------------------------------------------------------------------------
// sm83af_pkg
// operation codes, flag positions, constants and item types of the alu
// ----------------------------------------------------------------------------
package sm83af_pkg;

   localparam logic [4:0] KIND_ADD   = 5'd0;
   localparam logic [4:0] KIND_ADC   = 5'd1;
   localparam logic [4:0] KIND_SUB   = 5'd2;
   localparam logic [4:0] KIND_SBC   = 5'd3;
   localparam logic [4:0] KIND_AND   = 5'd4;
   localparam logic [4:0] KIND_XOR   = 5'd5;
   localparam logic [4:0] KIND_OR    = 5'd6;
   localparam logic [4:0] KIND_CP    = 5'd7;
   localparam logic [4:0] KIND_INC   = 5'd8;
   localparam logic [4:0] KIND_DEC   = 5'd9;
   localparam logic [4:0] KIND_RLCA  = 5'd10;
   localparam logic [4:0] KIND_RLA   = 5'd11;
   localparam logic [4:0] KIND_RRCA  = 5'd12;
   localparam logic [4:0] KIND_RRA   = 5'd13;
   localparam logic [4:0] KIND_RLC   = 5'd14;
   localparam logic [4:0] KIND_RRC   = 5'd15;
   localparam logic [4:0] KIND_RL    = 5'd16;
   localparam logic [4:0] KIND_RR    = 5'd17;
   localparam logic [4:0] KIND_SLA   = 5'd18;
   localparam logic [4:0] KIND_SRA   = 5'd19;
   localparam logic [4:0] KIND_SWAP  = 5'd20;
   localparam logic [4:0] KIND_SRL   = 5'd21;
   localparam logic [4:0] KIND_BIT   = 5'd22;
   localparam logic [4:0] KIND_RES   = 5'd23;
   localparam logic [4:0] KIND_SET   = 5'd24;
   localparam logic [4:0] KIND_DAA   = 5'd25;
   localparam logic [4:0] KIND_CPL   = 5'd26;
   localparam logic [4:0] KIND_CCF   = 5'd27;
   localparam logic [4:0] KIND_SCF   = 5'd28;
   localparam logic [4:0] KIND_ADD16 = 5'd29;
   localparam logic [4:0] KIND_ADDSP = 5'd30;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] DAA_LIMIT = 8'h99;
   localparam logic [7:0] DAA_HI    = 8'h60;
   localparam logic [7:0] DAA_LO    = 8'h06;
   localparam logic [3:0] NIB_LIMIT = 4'h9;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_back;
   } rsp_type;

   function automatic logic zero8(input logic [7:0] v);
      return (v == 8'h00);
   endfunction

endpackage

FILE: hdl/sm83_alu_flags_unit_core.sv
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit_core
// execute unit with z n h c flags: input register, alu, result register
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   req_kind .. req_flags_in   start, taken when busy is low
//  response  rsp_result .. rsp_write_b  rsp_valid strobe, one cycle
//
//  one item per clock, every clock; busy is always low
//  an item passes the input register, the alu and the result register
//  in that order; rsp_valid rises as the result register is loaded
//  reset clears the two valid bits only; no stall on the response side
// ----------------------------------------------------------------------------
`include "sm83_alu_flags_unit_core_macros.svh"

module sm83_alu_flags_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_kind,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_result,
   output logic [3:0]  rsp_flags_out,
   output logic        rsp_write_back
);

   sm83af_pkg::req_type req_ff;
   sm83af_pkg::req_type req_in;
   logic                req_valid_ff;
   logic                req_valid_in;
   sm83af_pkg::rsp_type alu_rsp;
   sm83af_pkg::rsp_type rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   assign busy = 1'b0;

   assign req_in       = '{kind:      req_kind,
                           operand_a: req_operand_a,
                           operand_b: req_operand_b,
                           bit_index: req_bit_index,
                           flags_in:  req_flags_in};
   assign req_valid_in = start & ~busy;
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= alu_rsp;
      end
   end

   sm83af_alu u_alu (
      .req (req_ff),
      .rsp (alu_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_ff.result;
   assign rsp_flags_out  = rsp_ff.flags_out;
   assign rsp_write_back = rsp_ff.write_back;

   property p_cp_no_write;
      (rsp_valid && $past(start, 2) && $past(req_kind, 2) == sm83af_pkg::KIND_CP)
         |-> !rsp_write_back;
   endproperty

   `SM83AF_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
   `SM83AF_ASSERT(a_item_returns, start |-> ##2 rsp_valid, "accepted item produced no response")
   `SM83AF_ASSERT(a_no_phantom, rsp_valid |-> $past(start, 2), "response without an item")
   `SM83AF_ASSERT(a_cp_no_write, p_cp_no_write, "compare wrote back")

endmodule

FILE: hdl/sm83af_alu.sv
// ----------------------------------------------------------------------------
// sm83af_alu
// single pass datapath: result, flags and write back for one item
// ----------------------------------------------------------------------------
module sm83af_alu (
   input  sm83af_pkg::req_type req,
   output sm83af_pkg::rsp_type rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        cy;
   logic [8:0]  add9;
   logic [4:0]  addh;
   logic [8:0]  sub9;
   logic [4:0]  subh;
   logic [16:0] add17;
   logic [12:0] add13;
   logic [15:0] sp_sum;
   logic [8:0]  sp9;
   logic [4:0]  sph;
   logic [7:0]  r8;
   logic [7:0]  daa_adj;
   logic        daa_hi;
   logic        daa_lo;
   logic [7:0]  bit_mask;
   logic [15:0] res;
   logic [3:0]  nf;
   logic        wr;

   always_comb begin
      a        = req.operand_a[7:0];
      b        = req.operand_b[7:0];
      cin      = req.flags_in[sm83af_pkg::FLAG_C];
      cy       = cin & ((req.kind == sm83af_pkg::KIND_ADC) || (req.kind == sm83af_pkg::KIND_SBC));
      add9     = {1'b0, a} + {1'b0, b} + {8'h00, cy};
      addh     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
      sub9     = {1'b0, a} - {1'b0, b} - {8'h00, cy};
      subh     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
      add17    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
      add13    = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
      sp_sum   = req.operand_a + {{8{b[7]}}, b};
      sp9      = {1'b0, req.operand_a[7:0]} + {1'b0, b};
      sph      = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};
      bit_mask = 8'h01 << req.bit_index;
      daa_hi   = 1'b0;
      daa_lo   = 1'b0;
      daa_adj  = 8'h00;
      r8       = a;
      res      = {8'h00, a};
      nf       = req.flags_in;
      wr       = 1'b1;

      case (req.kind)
         sm83af_pkg::KIND_ADD, sm83af_pkg::KIND_ADC: begin
            r8  = add9[7:0];
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 1'b0, addh[4], add9[8]};
         end
         sm83af_pkg::KIND_SUB, sm83af_pkg::KIND_SBC, sm83af_pkg::KIND_CP: begin
            r8  = sub9[7:0];
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 1'b1, subh[4], sub9[8]};
            wr  = (req.kind != sm83af_pkg::KIND_CP);
         end
         sm83af_pkg::KIND_AND: begin
            r8  = a & b;
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 1'b0, 1'b1, 1'b0};
         end
         sm83af_pkg::KIND_XOR: begin
            r8  = a ^ b;
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 3'b000};
         end
         sm83af_pkg::KIND_OR: begin
            r8  = a | b;
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 3'b000};
         end
         sm83af_pkg::KIND_INC: begin
            r8  = a + 8'h01;
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 1'b0, (a[3:0] == 4'hF), cin};
         end
         sm83af_pkg::KIND_DEC: begin
            r8  = a - 8'h01;
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 1'b1, (a[3:0] == 4'h0), cin};
         end
         sm83af_pkg::KIND_RLCA, sm83af_pkg::KIND_RLC: begin
            r8  = {a[6:0], a[7]};
            res = {8'h00, r8};
            nf  = {(req.kind == sm83af_pkg::KIND_RLC) & sm83af_pkg::zero8(r8), 2'b00, a[7]};
         end
         sm83af_pkg::KIND_RLA, sm83af_pkg::KIND_RL: begin
            r8  = {a[6:0], cin};
            res = {8'h00, r8};
            nf  = {(req.kind == sm83af_pkg::KIND_RL) & sm83af_pkg::zero8(r8), 2'b00, a[7]};
         end
         sm83af_pkg::KIND_RRCA, sm83af_pkg::KIND_RRC: begin
            r8  = {a[0], a[7:1]};
            res = {8'h00, r8};
            nf  = {(req.kind == sm83af_pkg::KIND_RRC) & sm83af_pkg::zero8(r8), 2'b00, a[0]};
         end
         sm83af_pkg::KIND_RRA, sm83af_pkg::KIND_RR: begin
            r8  = {cin, a[7:1]};
            res = {8'h00, r8};
            nf  = {(req.kind == sm83af_pkg::KIND_RR) & sm83af_pkg::zero8(r8), 2'b00, a[0]};
         end
         sm83af_pkg::KIND_SLA: begin
            r8  = {a[6:0], 1'b0};
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 2'b00, a[7]};
         end
         sm83af_pkg::KIND_SRA: begin
            r8  = {a[7], a[7:1]};
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 2'b00, a[0]};
         end
         sm83af_pkg::KIND_SRL: begin
            r8  = {1'b0, a[7:1]};
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 2'b00, a[0]};
         end
         sm83af_pkg::KIND_SWAP: begin
            r8  = {a[3:0], a[7:4]};
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), 3'b000};
         end
         sm83af_pkg::KIND_BIT: begin
            nf = {((a & bit_mask) == 8'h00), 1'b0, 1'b1, cin};
            wr = 1'b0;
         end
         sm83af_pkg::KIND_RES: begin
            res = {8'h00, a & ~bit_mask};
         end
         sm83af_pkg::KIND_SET: begin
            res = {8'h00, a | bit_mask};
         end
         sm83af_pkg::KIND_DAA: begin
            if (!req.flags_in[sm83af_pkg::FLAG_N]) begin
               daa_hi  = cin | (a > sm83af_pkg::DAA_LIMIT);
               daa_lo  = req.flags_in[sm83af_pkg::FLAG_H] | (a[3:0] > sm83af_pkg::NIB_LIMIT);
               daa_adj = (daa_hi ? sm83af_pkg::DAA_HI : 8'h00)
                       | (daa_lo ? sm83af_pkg::DAA_LO : 8'h00);
               r8      = a + daa_adj;
            end else begin
               daa_hi  = cin;
               daa_adj = (cin ? sm83af_pkg::DAA_HI : 8'h00)
                       | (req.flags_in[sm83af_pkg::FLAG_H] ? sm83af_pkg::DAA_LO : 8'h00);
               r8      = a - daa_adj;
            end
            res = {8'h00, r8};
            nf  = {sm83af_pkg::zero8(r8), req.flags_in[sm83af_pkg::FLAG_N], 1'b0,
                   daa_hi | cin};
         end
         sm83af_pkg::KIND_CPL: begin
            res = {8'h00, ~a};
            nf  = {req.flags_in[sm83af_pkg::FLAG_Z], 1'b1, 1'b1, cin};
         end
         sm83af_pkg::KIND_CCF: begin
            nf = {req.flags_in[sm83af_pkg::FLAG_Z], 2'b00, ~cin};
         end
         sm83af_pkg::KIND_SCF: begin
            nf = {req.flags_in[sm83af_pkg::FLAG_Z], 2'b00, 1'b1};
         end
         sm83af_pkg::KIND_ADD16: begin
            res = add17[15:0];
            nf  = {req.flags_in[sm83af_pkg::FLAG_Z], 1'b0, add13[12], add17[16]};
         end
         sm83af_pkg::KIND_ADDSP: begin
            res = sp_sum;
            nf  = {2'b00, sph[4], sp9[8]};
         end
         default: begin
            res = req.operand_a;
            wr  = 1'b0;
         end
      endcase

      rsp.result     = res;
      rsp.flags_out  = nf;
      rsp.write_back = wr;
   end

endmodule

FILE: tb/sm83_alu_flags_unit_core_checker.sv
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit_core_checker
// watches the request and response channels of the alu, works out the
// result, flags and write back of every accepted item and compares each
// response, in order, with the oldest outcome still outstanding
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sm83_alu_flags_unit_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [4:0]  req_kind,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_result,
   input  logic [3:0]  rsp_flags_out,
   input  logic        rsp_write_back,
   output int          fail_count,
   output int          in_flight
);

   sm83af_pkg::rsp_type outcome_queue[$];
   int                  failures = 0;

   function automatic sm83af_pkg::rsp_type alu_outcome(input sm83af_pkg::req_type op);
      logic [7:0]          a, b, r8, mask;
      logic [3:0]          f;
      logic                cin, cy, z, n, h, cf;
      logic [8:0]          s9;
      logic [4:0]          s5;
      logic [12:0]         s13;
      logic [16:0]         s17;
      sm83af_pkg::rsp_type o;
      a    = op.operand_a[7:0];
      b    = op.operand_b[7:0];
      f    = op.flags_in;
      cin  = f[sm83af_pkg::FLAG_C];
      z    = f[sm83af_pkg::FLAG_Z];
      n    = f[sm83af_pkg::FLAG_N];
      h    = f[sm83af_pkg::FLAG_H];
      cf   = f[sm83af_pkg::FLAG_C];
      mask = 8'h01 << op.bit_index;
      r8   = a;
      o.result     = {8'h00, a};
      o.write_back = 1'b1;
      case (op.kind)
         sm83af_pkg::KIND_ADD, sm83af_pkg::KIND_ADC: begin
            cy = (op.kind == sm83af_pkg::KIND_ADC) ? cin : 1'b0;
            s9 = {1'b0, a} + {1'b0, b} + 9'(cy);
            s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cy);
            r8 = s9[7:0];
            z = (r8 == 8'h00); n = 1'b0; h = s5[4]; cf = s9[8];
         end
         sm83af_pkg::KIND_SUB, sm83af_pkg::KIND_SBC, sm83af_pkg::KIND_CP: begin
            cy = (op.kind == sm83af_pkg::KIND_SBC) ? cin : 1'b0;
            s9 = {1'b0, a} - {1'b0, b} - 9'(cy);
            s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cy);
            r8 = s9[7:0];
            z = (r8 == 8'h00); n = 1'b1; h = s5[4]; cf = s9[8];
            if (op.kind == sm83af_pkg::KIND_CP) o.write_back = 1'b0;
         end
         sm83af_pkg::KIND_AND, sm83af_pkg::KIND_XOR, sm83af_pkg::KIND_OR: begin
            if (op.kind == sm83af_pkg::KIND_AND) r8 = a & b;
            else if (op.kind == sm83af_pkg::KIND_XOR) r8 = a ^ b;
            else r8 = a | b;
            z = (r8 == 8'h00); n = 1'b0; h = (op.kind == sm83af_pkg::KIND_AND); cf = 1'b0;
         end
         sm83af_pkg::KIND_INC: begin
            r8 = a + 8'h01;
            z = (r8 == 8'h00); n = 1'b0; h = (a[3:0] == 4'hF);
         end
         sm83af_pkg::KIND_DEC: begin
            r8 = a - 8'h01;
            z = (r8 == 8'h00); n = 1'b1; h = (a[3:0] == 4'h0);
         end
         sm83af_pkg::KIND_RLCA, sm83af_pkg::KIND_RLA,
         sm83af_pkg::KIND_RLC, sm83af_pkg::KIND_RL: begin
            cy = (op.kind == sm83af_pkg::KIND_RLA || op.kind == sm83af_pkg::KIND_RL)
               ? cin : a[7];
            r8 = {a[6:0], cy};
            z = (op.kind == sm83af_pkg::KIND_RLC || op.kind == sm83af_pkg::KIND_RL)
               ? (r8 == 8'h00) : 1'b0;
            n = 1'b0; h = 1'b0; cf = a[7];
         end
         sm83af_pkg::KIND_RRCA, sm83af_pkg::KIND_RRA,
         sm83af_pkg::KIND_RRC, sm83af_pkg::KIND_RR: begin
            cy = (op.kind == sm83af_pkg::KIND_RRA || op.kind == sm83af_pkg::KIND_RR)
               ? cin : a[0];
            r8 = {cy, a[7:1]};
            z = (op.kind == sm83af_pkg::KIND_RRC || op.kind == sm83af_pkg::KIND_RR)
               ? (r8 == 8'h00) : 1'b0;
            n = 1'b0; h = 1'b0; cf = a[0];
         end
         sm83af_pkg::KIND_SLA: begin
            r8 = {a[6:0], 1'b0};
            z = (r8 == 8'h00); n = 1'b0; h = 1'b0; cf = a[7];
         end
         sm83af_pkg::KIND_SRA, sm83af_pkg::KIND_SRL: begin
            r8 = {(op.kind == sm83af_pkg::KIND_SRA) ? a[7] : 1'b0, a[7:1]};
            z = (r8 == 8'h00); n = 1'b0; h = 1'b0; cf = a[0];
         end
         sm83af_pkg::KIND_SWAP: begin
            r8 = {a[3:0], a[7:4]};
            z = (r8 == 8'h00); n = 1'b0; h = 1'b0; cf = 1'b0;
         end
         sm83af_pkg::KIND_BIT: begin
            z = ~a[op.bit_index]; n = 1'b0; h = 1'b1;
            o.write_back = 1'b0;
         end
         sm83af_pkg::KIND_RES: r8 = a & ~mask;
         sm83af_pkg::KIND_SET: r8 = a | mask;
         sm83af_pkg::KIND_DAA: begin
            cy = cin;
            if (!f[sm83af_pkg::FLAG_N]) begin
               if (cin || a > sm83af_pkg::DAA_LIMIT) begin
                  r8 = r8 + sm83af_pkg::DAA_HI;
                  cy = 1'b1;
               end
               if (f[sm83af_pkg::FLAG_H] || a[3:0] > sm83af_pkg::NIB_LIMIT)
                  r8 = r8 + sm83af_pkg::DAA_LO;
            end else begin
               if (cin) r8 = r8 - sm83af_pkg::DAA_HI;
               if (f[sm83af_pkg::FLAG_H]) r8 = r8 - sm83af_pkg::DAA_LO;
            end
            z = (r8 == 8'h00); h = 1'b0; cf = cy;
         end
         sm83af_pkg::KIND_CPL: begin
            r8 = ~a;
            n = 1'b1; h = 1'b1;
         end
         sm83af_pkg::KIND_CCF: begin
            n = 1'b0; h = 1'b0; cf = ~cin;
         end
         sm83af_pkg::KIND_SCF: begin
            n = 1'b0; h = 1'b0; cf = 1'b1;
         end
         default: ;
      endcase
      o.result = {8'h00, r8};
      if (op.kind == sm83af_pkg::KIND_ADD16) begin
         s17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
         s13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
         o.result = s17[15:0];
         n = 1'b0; h = s13[12]; cf = s17[16];
      end else if (op.kind == sm83af_pkg::KIND_ADDSP) begin
         s17 = {1'b0, op.operand_a} + {1'b0, {8{b[7]}}, b};
         s9  = {1'b0, op.operand_a[7:0]} + {1'b0, b};
         s5  = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
         o.result = s17[15:0];
         z = 1'b0; n = 1'b0; h = s5[4]; cf = s9[8];
      end else if (op.kind > sm83af_pkg::KIND_ADDSP) begin
         o.result     = op.operand_a;
         o.write_back = 1'b0;
      end
      o.flags_out = {z, n, h, cf};
      return o;
   endfunction

   always @(posedge clock) begin
      sm83af_pkg::req_type op;
      sm83af_pkg::rsp_type want, seen;
      if (reset) begin
         outcome_queue.delete();
      end else begin
         if (rsp_valid) begin
            seen.result     = rsp_result;
            seen.flags_out  = rsp_flags_out;
            seen.write_back = rsp_write_back;
            if (outcome_queue.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: response with no item outstanding: result %h flags %b wb %b",
                           $realtime, seen.result, seen.flags_out, seen.write_back);
            end else begin
               want = outcome_queue.pop_front();
               if (seen.result !== want.result || seen.flags_out !== want.flags_out ||
                   seen.write_back !== want.write_back) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: mismatch: result %h/%h flags %b/%b wb %b/%b (expected/actual)",
                              $realtime, want.result, seen.result, want.flags_out,
                              seen.flags_out, want.write_back, seen.write_back);
               end
            end
         end
         if (start && !busy) begin
            op.kind      = req_kind;
            op.operand_a = req_operand_a;
            op.operand_b = req_operand_b;
            op.bit_index = req_bit_index;
            op.flags_in  = req_flags_in;
            outcome_queue.push_back(alu_outcome(op));
         end
      end
      in_flight  <= outcome_queue.size();
      fail_count <= failures;
   end

endmodule

FILE: tb/sm83_alu_flags_unit_core_tb.sv
// ----------------------------------------------------------------------------
// sm83_alu_flags_unit_core_tb
// drives every alu operation, first with extreme operands and a few corner
// values, then with random items biased toward edge and bcd values, with
// random start gaps; the checker beside the unit predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sm83_alu_flags_unit_core_tb;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int RANDOM_ITEMS = 1550;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_kind;
   logic [15:0] req_operand_a;
   logic [15:0] req_operand_b;
   logic [2:0]  req_bit_index;
   logic [3:0]  req_flags_in;
   logic        rsp_valid;
   logic [15:0] rsp_result;
   logic [3:0]  rsp_flags_out;
   logic        rsp_write_back;
   int          fail_count;
   int          in_flight;
   int          elapsed_ticks = 0;
   bit          steady = 1'b0;

   sm83_alu_flags_unit_core uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_bit_index  (req_bit_index),
      .req_flags_in   (req_flags_in),
      .rsp_valid      (rsp_valid),
      .rsp_result     (rsp_result),
      .rsp_flags_out  (rsp_flags_out),
      .rsp_write_back (rsp_write_back)
   );

   sm83_alu_flags_unit_core_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_bit_index  (req_bit_index),
      .req_flags_in   (req_flags_in),
      .rsp_valid      (rsp_valid),
      .rsp_result     (rsp_result),
      .rsp_flags_out  (rsp_flags_out),
      .rsp_write_back (rsp_write_back),
      .fail_count     (fail_count),
      .in_flight      (in_flight)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      elapsed_ticks <= elapsed_ticks + 1;
      if (elapsed_ticks >= CYCLE_LIMIT) begin
         $display("FAIL sm83_alu_flags_unit_core");
         $finish;
      end
   end

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h00FF;
         3: return {8'($urandom), 8'h80};
         4: return 16'h0FFF;
         5: return {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         6: return {8'($urandom), 4'($urandom), 4'hF};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic issue_op(input sm83af_pkg::req_type op);
      int gap;
      if (!steady && $urandom_range(0, 99) < 3) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= op.kind;
      req_operand_a <= op.operand_a;
      req_operand_b <= op.operand_b;
      req_bit_index <= op.bit_index;
      req_flags_in  <= op.flags_in;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      sm83af_pkg::req_type op;
      int                  k;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_kind      <= sm83af_pkg::KIND_ADD;
      req_operand_a <= 16'h0000;
      req_operand_b <= 16'h0000;
      req_bit_index <= 3'd0;
      req_flags_in  <= 4'h0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every kind, unused one included, with extreme operands
      for (k = 0; k < 32; k++) begin
         op.kind      = 5'(k);
         op.operand_a = k[0] ? 16'hFFFF : 16'h0000;
         op.operand_b = k[1] ? 16'h0001 : 16'hFFFF;
         op.bit_index = 3'(k);
         op.flags_in  = 4'(k);
         issue_op(op);
      end
      issue_op('{sm83af_pkg::KIND_ADC, 16'hFF0F, 16'hFF00, 3'd0, 4'b0001});
      issue_op('{sm83af_pkg::KIND_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000});
      issue_op('{sm83af_pkg::KIND_ADDSP, 16'h00FF, 16'hFF80, 3'd0, 4'b1111});

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         steady       = (k >= 600 && k < 900);
         op.kind      = 5'($urandom_range(0, 31));
         op.operand_a = pick_operand();
         op.operand_b = pick_operand();
         op.bit_index = 3'($urandom);
         op.flags_in  = 4'($urandom);
         issue_op(op);
      end
      start <= 1'b0;

      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("PASS sm83_alu_flags_unit_core");
      else
         $display("FAIL sm83_alu_flags_unit_core");
      $finish;
   end

endmodule

FILE: sm83_alu_flags_unit_core.f
+incdir+hdl
hdl/sm83af_pkg.sv
hdl/sm83af_alu.sv
hdl/sm83_alu_flags_unit_core.sv
tb/sm83_alu_flags_unit_core_checker.sv
tb/sm83_alu_flags_unit_core_tb.sv
